// ===== hw/rtl/pdfp_pkg.sv =====
package pdfp_pkg;

  localparam int PROB_W      = 16;
  localparam int MASS_W      = 24;
  localparam int TGT_W       = PROB_W + 1;
  localparam int REG_W       = 4;
  localparam int CNT_W       = 5;
  localparam int MAX_REGIONS = 16;
  localparam int DIV_STEPS   = TGT_W;
  localparam int STEP_W      = 5;

  localparam logic [TGT_W-1:0]  ONE_FIX  = TGT_W'(1) << PROB_W;
  localparam logic [MASS_W-1:0] MASS_MAX = '1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

  // register addresses (word index)
  localparam logic REG_COMMAND_COUNT = 1'b0;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              last_bin;
  } item_t;

  typedef struct packed {
    logic              restart;
    logic [CNT_W-1:0]  count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TGT_W-1:0]  dividend;
    logic [REG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TGT_W-1:0]  quotient;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) r = CNT_W'(1);
    if (n > CNT_W'(MAX_REGIONS)) r = CNT_W'(MAX_REGIONS);
    return r;
  endfunction

  // first-region target, one over the count
  function automatic logic [TGT_W-1:0] frame_target(logic [CNT_W-1:0] n);
    logic [TGT_W-1:0] r;
    case (n)
      5'd1:    r = TGT_W'(ONE_FIX / 1);
      5'd2:    r = TGT_W'(ONE_FIX / 2);
      5'd3:    r = TGT_W'(ONE_FIX / 3);
      5'd4:    r = TGT_W'(ONE_FIX / 4);
      5'd5:    r = TGT_W'(ONE_FIX / 5);
      5'd6:    r = TGT_W'(ONE_FIX / 6);
      5'd7:    r = TGT_W'(ONE_FIX / 7);
      5'd8:    r = TGT_W'(ONE_FIX / 8);
      5'd9:    r = TGT_W'(ONE_FIX / 9);
      5'd10:   r = TGT_W'(ONE_FIX / 10);
      5'd11:   r = TGT_W'(ONE_FIX / 11);
      5'd12:   r = TGT_W'(ONE_FIX / 12);
      5'd13:   r = TGT_W'(ONE_FIX / 13);
      5'd14:   r = TGT_W'(ONE_FIX / 14);
      5'd15:   r = TGT_W'(ONE_FIX / 15);
      default: r = TGT_W'(ONE_FIX / MAX_REGIONS);
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/balanced_pdf_partitioner_top.sv =====
// Balanced PDF partitioner. Stream in distribution bins (probability in s_tdata,
// s_tlast on the last bin of a frame); each bin comes back on the master side with
// the command region it falls in and the same tlast. Bins pass at one per cycle
// while the region stays the same and the output is not stalled. A region change
// before a frame's last bin starts a serial divider for the next region's target,
// one quotient bit per cycle; the following bin waits for it. N = command_count is
// clamped to 1..16, and a frame has at most N-1 region changes. A two-entry input
// queue takes up to two bins while the back end waits. Writing command_count
// (address 0) restarts the frame; write it only while the block is idle.
module balanced_pdf_partitioner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] probability
  input  logic        s_tlast,   // last_bin
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] region_index, [7:4] zero
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pdfp_pkg::CNT_W-1:0] command_count;
  logic                       wr_en;
  pdfp_pkg::cfg_t             cfg;
  logic                       q_valid;
  logic                       q_ready;
  pdfp_pkg::item_t            q_item;
  pdfp_pkg::div_req_t         div_req;
  pdfp_pkg::div_rsp_t         div_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[2] == pdfp_pkg::REG_COMMAND_COUNT);
  assign cfg    = '{restart: wr_en, count: pwdata[pdfp_pkg::CNT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      command_count <= pdfp_pkg::COUNT_RESET;
    end else if (wr_en) begin
      command_count <= pwdata[pdfp_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == pdfp_pkg::REG_COMMAND_COUNT)
                ? 32'(command_count) : 32'd0;

  pdfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  pdfp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pdfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/pdfp_front.sv =====
module pdfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // [15:0] probability
  input  logic           s_tlast,
  output logic           q_valid,
  input  logic           q_ready,
  output pdfp_pkg::item_t q_item
);

  pdfp_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_ready && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{probability: s_tdata, last_bin: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/pdfp_div.sv =====
module pdfp_div (
  input  logic               clk,
  input  logic               rst,
  input  pdfp_pkg::div_req_t req,
  output pdfp_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic [pdfp_pkg::STEP_W-1:0]     steps;
  logic [pdfp_pkg::REG_W-1:0]      rem;
  logic [pdfp_pkg::REG_W-1:0]      divisor;
  logic [pdfp_pkg::TGT_W-1:0]      quo;
  logic                            done;
  logic [pdfp_pkg::REG_W:0]        trial;
  logic                            fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[pdfp_pkg::TGT_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? pdfp_pkg::REG_W'(trial - {1'b0, divisor})
                  : pdfp_pkg::REG_W'(trial);
      quo <= {quo[pdfp_pkg::TGT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == pdfp_pkg::STEP_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        steps <= pdfp_pkg::STEP_W'(pdfp_pkg::DIV_STEPS);
      end else if (busy) begin
        steps <= steps - pdfp_pkg::STEP_W'(1);
        if (steps == pdfp_pkg::STEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

// ===== hw/rtl/pdfp_back.sv =====
module pdfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pdfp_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  pdfp_pkg::item_t      q_item,
  output pdfp_pkg::div_req_t   div_req,
  input  pdfp_pkg::div_rsp_t   div_rsp,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [3:0] region_index, [7:4] zero
  output logic                 m_tlast
);

  logic [pdfp_pkg::CNT_W-1:0]  n_eff;
  logic [pdfp_pkg::REG_W-1:0]  region;
  logic [pdfp_pkg::MASS_W-1:0] mass;
  logic [pdfp_pkg::TGT_W-1:0]  target;
  logic [pdfp_pkg::TGT_W-1:0]  committed;
  logic                        waiting;
  logic [pdfp_pkg::REG_W-1:0]  out_region;

  logic                        take;
  logic [pdfp_pkg::MASS_W:0]   sum_raw;
  logic [pdfp_pkg::MASS_W-1:0] sum;
  logic                        advance;
  logic [pdfp_pkg::TGT_W-1:0]  committed_next;
  logic [pdfp_pkg::TGT_W-1:0]  open_mass;
  logic [pdfp_pkg::REG_W-1:0]  left;
  logic [pdfp_pkg::REG_W-1:0]  region_next;

  assign take    = q_valid && !waiting && (!m_tvalid || m_tready);
  assign q_ready = take;

  assign sum_raw = {1'b0, mass} + (pdfp_pkg::MASS_W + 1)'(q_item.probability);
  assign sum     = sum_raw[pdfp_pkg::MASS_W] ? pdfp_pkg::MASS_MAX
                                             : sum_raw[pdfp_pkg::MASS_W-1:0];
  assign advance = (sum > pdfp_pkg::MASS_W'(target)) &&
                   (({1'b0, region} + pdfp_pkg::CNT_W'(1)) < n_eff);

  assign committed_next = committed + target;
  assign open_mass = (committed_next >= pdfp_pkg::ONE_FIX) ? '0
                                                           : pdfp_pkg::ONE_FIX - committed_next;
  assign left        = pdfp_pkg::REG_W'(n_eff - {1'b0, region} - pdfp_pkg::CNT_W'(1));
  assign region_next = advance ? region + pdfp_pkg::REG_W'(1) : region;

  // a region change on a frame's last bin needs no new target
  assign div_req = '{start: take && advance && !q_item.last_bin,
                     dividend: open_mass, divisor: left};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff     <= pdfp_pkg::eff_count(pdfp_pkg::COUNT_RESET);
      region    <= '0;
      mass      <= '0;
      target    <= pdfp_pkg::frame_target(pdfp_pkg::eff_count(pdfp_pkg::COUNT_RESET));
      committed <= '0;
      waiting   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (cfg.restart) begin
      n_eff     <= pdfp_pkg::eff_count(cfg.count);
      region    <= '0;
      mass      <= '0;
      target    <= pdfp_pkg::frame_target(pdfp_pkg::eff_count(cfg.count));
      committed <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (div_rsp.done) begin
        target  <= div_rsp.quotient;
        waiting <= 1'b0;
      end
      if (take) begin
        m_tvalid <= 1'b1;
        if (q_item.last_bin) begin
          region    <= '0;
          mass      <= '0;
          target    <= pdfp_pkg::frame_target(n_eff);
          committed <= '0;
        end else if (advance) begin
          region    <= region_next;
          mass      <= pdfp_pkg::MASS_W'(q_item.probability);
          committed <= committed_next;
          waiting   <= 1'b1;
        end else begin
          mass <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_region <= region_next;
      m_tlast    <= q_item.last_bin;
    end
  end

  assign m_tdata = {4'b0000, out_region};

endmodule

// ===== bench/balanced_pdf_partitioner_top_tb.sv =====
`timescale 1ns / 1ps

module balanced_pdf_partitioner_top_tb;

  localparam int unsigned UNIT_MASS    = 65536;       // 1.0 in Q1.16
  localparam int unsigned MASS_CEIL    = 24'hFFFFFF;
  localparam int unsigned REGION_LIMIT = 16;
  localparam int unsigned PROB_MAX     = 16'hFFFF;
  localparam logic [2:0]  ADDR_COMMAND_COUNT = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED      = 3'd4;
  localparam int          DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [3:0] region;
    logic       frame_end;
  } bin_region_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [15:0] probability
  logic        s_tlast = 1'b0;  // last_bin
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [3:0] region_index, [7:4] zero
  logic        m_tlast;         // frame_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  balanced_pdf_partitioner_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // partition state mirror
  logic [4:0]  count_reg;
  int unsigned region_now;
  int unsigned region_mass;
  int unsigned region_target;
  int unsigned committed_mass;

  bin_region_t pending_regions[$];
  int unsigned errors = 0;
  int unsigned bins_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned writes_done = 0;
  bit          sender_idles = 1'b1;
  bit          sink_idles = 1'b1;
  int unsigned stall_left = 0;

  function automatic int unsigned active_regions(logic [4:0] c);
    if (c == 5'd0) return 1;
    if (c > REGION_LIMIT) return REGION_LIMIT;
    return 32'(c);
  endfunction

  task automatic restart_partition();
    region_now     = 0;
    region_mass    = 0;
    region_target  = UNIT_MASS / active_regions(count_reg);
    committed_mass = 0;
  endtask

  task automatic assign_region(input logic [15:0] p, input logic last,
                               output bin_region_t r);
    int unsigned n, total, open_mass;
    n = active_regions(count_reg);
    total = region_mass + p;
    if (total > MASS_CEIL) total = MASS_CEIL;
    // strictly above target and a region left: this bin opens the next region
    if (total > region_target && region_now + 1 < n) begin
      committed_mass += region_target;
      open_mass = (committed_mass >= UNIT_MASS) ? 0 : UNIT_MASS - committed_mass;
      region_target = open_mass / (n - region_now - 1);
      region_now++;
      region_mass = p;
    end else begin
      region_mass = total;
    end
    r.region    = region_now[3:0];
    r.frame_end = last;
    if (last) restart_partition();
  endtask

  always @(posedge clk) begin : monitor
    bin_region_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        assign_region(s_tdata, s_tlast, want);
        pending_regions.push_back(want);
        bins_accepted++;
      end
      if (m_tvalid && m_tready) begin
        got.region    = m_tdata[3:0];
        got.frame_end = m_tlast;
        results_seen++;
        if (pending_regions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual region %0d last %0b",
                   $time, got.region, got.frame_end);
          errors++;
        end else begin
          want = pending_regions.pop_front();
          if (got.region !== want.region) begin
            $display("%0t: region_index expected %0d actual %0d",
                     $time, want.region, got.region);
            errors++;
          end
          if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.frame_end, got.frame_end);
            errors++;
          end
        end
      end
    end
    // result side back-pressure in bursts
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (sink_idles && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_bin(input logic [15:0] p, input logic last);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_partitioner();
    s_tvalid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    drain_partitioner();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COMMAND_COUNT) begin
      count_reg = value[4:0];
      restart_partition();
    end
    writes_done++;
  endtask

  // shaped frames spread roughly 1.0 of mass over the bins; others are noise
  task automatic send_frame(input int unsigned len, input bit shaped);
    int unsigned left_mass, p;
    left_mass = UNIT_MASS;
    for (int i = 0; i < len; i++) begin
      if (!shaped) p = $urandom_range(0, PROB_MAX);
      else if (i == len - 1) p = left_mass;
      else p = $urandom_range(0, 2 * left_mass / (len - i));
      if (p > PROB_MAX) p = PROB_MAX;
      left_mass -= (p < left_mass) ? p : left_mass;
      send_bin(p[15:0], i == len - 1);
    end
  endtask

  task automatic test_reset_directed();
    // reset count of 4: exact-target ties stay, overshoot advances
    send_bin(16'h4000, 1'b0);
    send_bin(16'h4000, 1'b0);
    send_bin(16'h4000, 1'b0);
    send_bin(16'h4000, 1'b1);
    send_bin(16'h0000, 1'b1);
    send_bin(16'hFFFF, 1'b1);
    for (int i = 0; i < 7; i++) send_bin(16'hFFFF, i == 6);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h3FFF, 1'b0);
    send_bin(16'h0002, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'h5555, 1'b1);
    // an address with no register behind it leaves the count alone
    write_register(ADDR_UNMAPPED, 32'd2);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'hFFFF, 1'b1);
  endtask

  task automatic test_count_limits();
    logic [4:0] counts[8] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd3, 5'd15};
    foreach (counts[k]) begin
      write_register(ADDR_COMMAND_COUNT, {27'd0, counts[k]});
      send_frame(2 * active_regions(counts[k]) + 1, 1'b1);
      send_frame($urandom_range(1, 40), 1'b1);
      for (int i = 0; i < 20; i++) send_bin(16'hFFFF, i == 19);
    end
  endtask

  task automatic test_midframe_write();
    write_register(ADDR_COMMAND_COUNT, 32'd8);
    for (int i = 0; i < 5; i++) send_bin(16'($urandom_range(8000, 20000)), 1'b0);
    // the write drops the open frame
    write_register(ADDR_COMMAND_COUNT, 32'd5);
    send_frame(12, 1'b1);
  endtask

  task automatic test_mass_saturation();
    write_register(ADDR_COMMAND_COUNT, 32'd1);
    for (int i = 0; i < 270; i++) send_bin(16'hFFFF, i == 269);
    send_frame(6, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [4:0] c;
    while (bins_accepted < 1050) begin
      c = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      write_register(ADDR_COMMAND_COUNT, {27'd0, c});
      sender_idles = $urandom_range(0, 3) != 0;
      sink_idles   = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 4))
        send_frame($urandom_range(1, 3 * active_regions(c) + 8),
                   $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_full_rate();
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    write_register(ADDR_COMMAND_COUNT, {27'd0, 5'($urandom_range(2, 16))});
    repeat (6) send_frame($urandom_range(10, 30), 1'b1);
    write_register(ADDR_COMMAND_COUNT, 32'd16);
    send_frame(40, 1'b1);
    send_frame(20, 1'b0);
    drain_partitioner();
  endtask

  initial begin
    count_reg = 5'd4;
    restart_partition();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_directed();
    test_count_limits();
    test_midframe_write();
    test_mass_saturation();
    test_random_traffic();
    test_full_rate();
    $display("Run covered %0d bins and %0d results over %0d register writes,", bins_accepted,
             results_seen, writes_done);
    $display("counts 0 to 31 incl. clamped ones, mid-frame restart and mass saturation");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_regions.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
